/* rtl/pps_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int TIME_W          = 16;
    localparam int PRIO_W          = 8;
    localparam int SLOT_W          = 4;
    localparam int CMD_W           = 2;
    localparam int STATUS_W        = 2;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_BURST = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [TIME_W-1:0] arrival_time;
        logic [TIME_W-1:0] burst_length;
        logic [PRIO_W-1:0] prio;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                ran;
        logic [SLOT_W-1:0]   slot;
        logic                finished;
        logic [TIME_W-1:0]   completion_time;
        logic [TIME_W-1:0]   turnaround;
        logic [TIME_W-1:0]   waiting;
        logic                all_done;
    } t_out;

    typedef struct packed {
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [TIME_W-1:0] remaining;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FETCH,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic accept;
        logic scan_rd;
        logic best_rd;
        logic update;
    } t_ctrl;

    typedef struct packed {
        logic is_tick;
        logic count_zero;
        logic scan_last;
    } t_stat;

endpackage

`default_nettype wire

/* rtl/pps_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module pps_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    input  wire pps_pkg::t_stat i_stat,
    output pps_pkg::t_ctrl      o_ctrl,
    output logic                busy
);
    import pps_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        busy    = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_ctrl.accept = 1'b1;
                    if (i_stat.is_tick) begin
                        n_state = i_stat.count_zero ? S_FETCH : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_ctrl.scan_rd = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FETCH;
            end
            S_FETCH: begin
                o_ctrl.best_rd = 1'b1;
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                o_ctrl.update = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/pps_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module pps_datapath #(
    parameter int MAX_ENTRIES = pps_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire pps_pkg::t_in   i_in,
    input  wire pps_pkg::t_ctrl i_ctrl,
    output pps_pkg::t_stat      o_stat,
    output logic                o_valid,
    output pps_pkg::t_out       o_result
);
    import pps_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int EXT_W = IDX_W + SLOT_W;

    t_entry r_mem [MAX_ENTRIES];
    t_entry r_rd_data;

    logic [MAX_ENTRIES-1:0] r_done, n_done;
    logic [CNT_W-1:0]       r_entry_count, n_entry_count;
    logic [CNT_W-1:0]       r_done_count, n_done_count;
    logic [TIME_W-1:0]      r_now, n_now;
    logic [IDX_W-1:0]       r_scan_idx, n_scan_idx;
    logic [IDX_W-1:0]       r_rd_idx;
    logic                   r_rd_vld;
    logic [IDX_W-1:0]       r_best_idx, n_best_idx;
    logic [PRIO_W-1:0]      r_best_prio, n_best_prio;
    logic                   r_found, n_found;
    logic                   r_valid, n_valid;
    t_out                   r_res, n_res;

    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    t_entry            wr_data;
    logic [IDX_W-1:0]  load_idx;
    logic [EXT_W-1:0]  load_ext;
    logic [EXT_W-1:0]  best_ext;
    logic              ready;
    logic [TIME_W-1:0] now_next;
    logic [TIME_W-1:0] rem_new;
    logic [TIME_W-1:0] tat;

    assign load_idx = r_entry_count[IDX_W-1:0];
    assign load_ext = EXT_W'(load_idx);
    assign best_ext = EXT_W'(r_best_idx);
    assign rd_addr  = i_ctrl.best_rd ? r_best_idx : r_scan_idx;
    assign now_next = (r_now == TIME_MAX) ? r_now : r_now + 1'b1;
    assign rem_new  = r_rd_data.remaining - 1'b1;
    assign tat      = now_next - r_rd_data.arrival;
    assign ready    = r_rd_vld && !r_done[r_rd_idx] && (r_rd_data.remaining != '0)
                      && (r_rd_data.arrival <= r_now);

    assign o_stat.is_tick    = (i_in.command == CMD_TICK);
    assign o_stat.count_zero = (r_entry_count == '0);
    assign o_stat.scan_last  = ((CNT_W'(r_scan_idx) + 1'b1) == r_entry_count);

    always_comb begin
        n_done        = r_done;
        n_entry_count = r_entry_count;
        n_done_count  = r_done_count;
        n_now         = r_now;
        n_scan_idx    = r_scan_idx;
        n_best_idx    = r_best_idx;
        n_best_prio   = r_best_prio;
        n_found       = r_found;
        n_valid       = 1'b0;
        n_res         = '0;
        wr_en         = 1'b0;
        wr_addr       = load_idx;
        wr_data.arrival   = i_in.arrival_time;
        wr_data.burst     = i_in.burst_length;
        wr_data.remaining = i_in.burst_length;
        wr_data.prio      = i_in.prio;

        if (i_ctrl.accept) begin
            n_scan_idx  = '0;
            n_best_idx  = '0;
            n_best_prio = '0;
            n_found     = 1'b0;
            unique case (i_in.command)
                CMD_LOAD: begin
                    n_valid = 1'b1;
                    if (r_entry_count == CNT_W'(MAX_ENTRIES)) begin
                        n_res.status = STATUS_FULL;
                    end else if (i_in.burst_length == '0) begin
                        n_res.status = STATUS_ZERO_BURST;
                    end else begin
                        wr_en              = 1'b1;
                        n_done[load_idx]   = 1'b0;
                        n_entry_count      = r_entry_count + 1'b1;
                        n_res.slot         = load_ext[SLOT_W-1:0];
                    end
                end
                CMD_CLEAR: begin
                    n_valid       = 1'b1;
                    n_done        = '0;
                    n_entry_count = '0;
                    n_done_count  = '0;
                    n_now         = '0;
                end
                CMD_TICK: begin
                end
                default: begin
                    n_valid = 1'b1;
                end
            endcase
        end

        if (i_ctrl.scan_rd) begin
            n_scan_idx = r_scan_idx + 1'b1;
        end

        if (ready && (!r_found || (r_rd_data.prio < r_best_prio))) begin
            n_found     = 1'b1;
            n_best_idx  = r_rd_idx;
            n_best_prio = r_rd_data.prio;
        end

        if (i_ctrl.update) begin
            n_valid = 1'b1;
            n_now   = now_next;
            if (r_found) begin
                wr_en             = 1'b1;
                wr_addr           = r_best_idx;
                wr_data           = r_rd_data;
                wr_data.remaining = rem_new;
                n_res.ran         = 1'b1;
                n_res.slot        = best_ext[SLOT_W-1:0];
                if (rem_new == '0) begin
                    n_done[r_best_idx]    = 1'b1;
                    n_done_count          = r_done_count + 1'b1;
                    n_res.finished        = 1'b1;
                    n_res.completion_time = now_next;
                    n_res.turnaround      = tat;
                    n_res.waiting         = (tat >= r_rd_data.burst) ?
                                            tat - r_rd_data.burst : '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done        <= '0;
            r_entry_count <= '0;
            r_done_count  <= '0;
            r_now         <= '0;
            r_scan_idx    <= '0;
            r_rd_vld      <= 1'b0;
            r_found       <= 1'b0;
            r_valid       <= 1'b0;
        end else begin
            r_done        <= n_done;
            r_entry_count <= n_entry_count;
            r_done_count  <= n_done_count;
            r_now         <= n_now;
            r_scan_idx    <= n_scan_idx;
            r_rd_vld      <= i_ctrl.scan_rd;
            r_found       <= n_found;
            r_valid       <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx    <= r_scan_idx;
        r_best_idx  <= n_best_idx;
        r_best_prio <= n_best_prio;
        r_res       <= n_res;
    end

    always_comb begin
        o_result          = r_res;
        o_result.all_done = (r_done_count == r_entry_count);
    end

    assign o_valid = r_valid;

endmodule

`default_nettype wire

/* rtl/preemptive_priority_scheduler.sv */
`timescale 1ns / 1ps
`default_nettype none

// Preemptive priority scheduler over a table of MAX_ENTRIES process slots.
// A command is taken when start is high and busy is low; its single result
// appears on o_result for exactly one cycle with o_valid high, and must be
// captured then since the block cannot be stalled. Load, clear and unknown
// commands return their result in the cycle after acceptance.
// A tick walks the process table one slot per cycle through the table
// memory's single read port (no walk with an empty table), then fetches and
// updates the chosen slot: it keeps busy high until the update is done, and
// its result shows in the first cycle busy is low again, when the next
// command may already be taken.
module preemptive_priority_scheduler #(
    parameter int MAX_ENTRIES = pps_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    input  wire pps_pkg::t_in   i_in,
    output logic                busy,
    output logic                o_valid,
    output pps_pkg::t_out       o_result
);
    import pps_pkg::*;

    t_ctrl ctrl;
    t_stat stat;

    pps_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_ctrl  (ctrl),
        .busy    (busy)
    );

    pps_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_ctrl   (ctrl),
        .o_stat   (stat),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

/* test/preemptive_priority_scheduler_tb.sv */
`timescale 1ns / 1ps

module preemptive_priority_scheduler_tb;
    import pps_pkg::*;

    localparam int MAX_SLOTS = MAX_ENTRIES_DEF;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    class sched_scoreboard;
        t_entry proc_tab [MAX_SLOTS];
        bit done_mask [MAX_SLOTS];
        int n_loaded;
        int n_done;
        int unsigned clock_now;
        t_out pending_reports [$];
        int errors;
        int n_loads, n_ticks, n_idle, n_finished, n_clamped;
        int n_full, n_zero, n_clears, n_unknown;

        function new();
            clear_state();
            errors = 0;
        endfunction

        function void clear_state();
            foreach (done_mask[k]) done_mask[k] = 1'b0;
            n_loaded = 0;
            n_done = 0;
            clock_now = 0;
        endfunction

        function t_out schedule_step(t_in c);
            t_out r;
            int pick;
            logic [PRIO_W-1:0] pick_prio;
            int tat;
            r = '0;
            pick = -1;
            pick_prio = '0;
            case (c.command)
                CMD_LOAD: begin
                    if (n_loaded >= MAX_SLOTS) begin
                        r.status = STATUS_FULL;
                        n_full++;
                    end else if (c.burst_length == '0) begin
                        r.status = STATUS_ZERO_BURST;
                        n_zero++;
                    end else begin
                        proc_tab[n_loaded] = '{arrival: c.arrival_time,
                                               burst: c.burst_length,
                                               remaining: c.burst_length,
                                               prio: c.prio};
                        done_mask[n_loaded] = 1'b0;
                        r.slot = SLOT_W'(n_loaded);
                        n_loaded++;
                        n_loads++;
                    end
                end
                CMD_TICK: begin
                    n_ticks++;
                    for (int k = 0; k < n_loaded; k++) begin
                        if (!done_mask[k] && proc_tab[k].remaining != '0 &&
                            int'(proc_tab[k].arrival) <= int'(clock_now)) begin
                            if (pick < 0 || proc_tab[k].prio < pick_prio) begin
                                pick = k;
                                pick_prio = proc_tab[k].prio;
                            end
                        end
                    end
                    if (clock_now < int'(TIME_MAX)) clock_now++;
                    if (pick >= 0) begin
                        r.ran = 1'b1;
                        r.slot = SLOT_W'(pick);
                        proc_tab[pick].remaining = proc_tab[pick].remaining - 1'b1;
                        if (proc_tab[pick].remaining == '0) begin
                            done_mask[pick] = 1'b1;
                            n_done++;
                            n_finished++;
                            tat = int'(clock_now) - int'(proc_tab[pick].arrival);
                            r.finished = 1'b1;
                            r.completion_time = clock_now[TIME_W-1:0];
                            r.turnaround = tat[TIME_W-1:0];
                            if (tat >= int'(proc_tab[pick].burst)) begin
                                r.waiting = TIME_W'(tat - int'(proc_tab[pick].burst));
                            end else begin
                                r.waiting = '0;
                                n_clamped++;
                            end
                        end
                    end else begin
                        n_idle++;
                    end
                end
                CMD_CLEAR: begin
                    clear_state();
                    n_clears++;
                end
                default: begin
                    n_unknown++;
                end
            endcase
            r.all_done = (n_done == n_loaded);
            return r;
        endfunction

        function void note_command(t_in c);
            pending_reports.push_back(schedule_step(c));
        endfunction

        function bit table_drained();
            return n_done == n_loaded;
        endfunction

        function void cmp_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
            if (got_v !== exp_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(t_out got);
            t_out exp_r;
            if (pending_reports.size() == 0) begin
                $error("result transaction with nothing expected");
                errors++;
                return;
            end
            exp_r = pending_reports.pop_front();
            cmp_field("status", exp_r.status, got.status);
            cmp_field("ran", exp_r.ran, got.ran);
            cmp_field("slot", exp_r.slot, got.slot);
            cmp_field("finished", exp_r.finished, got.finished);
            cmp_field("completion_time", exp_r.completion_time, got.completion_time);
            cmp_field("turnaround", exp_r.turnaround, got.turnaround);
            cmp_field("waiting", exp_r.waiting, got.waiting);
            cmp_field("all_done", exp_r.all_done, got.all_done);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_in  i_in;
    logic busy;
    logic o_valid;
    t_out o_result;

    sched_scoreboard sb = new();
    int items_sent;
    int seq_no;

    preemptive_priority_scheduler u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_in     (i_in),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("tb: failure");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_result);
    end

    function automatic t_in mk(logic [CMD_W-1:0] cmd, logic [TIME_W-1:0] arr,
                               logic [TIME_W-1:0] burst, logic [PRIO_W-1:0] prio);
        t_in c;
        c.command = cmd;
        c.arrival_time = arr;
        c.burst_length = burst;
        c.prio = prio;
        return c;
    endfunction

    function automatic t_in rand_noise();
        return mk(CMD_W'($urandom_range(3)), TIME_W'($urandom_range(65535)),
                  TIME_W'($urandom_range(65535)), PRIO_W'($urandom_range(255)));
    endfunction

    function automatic t_in rand_load();
        int r;
        logic [TIME_W-1:0] arr;
        logic [TIME_W-1:0] burst;
        logic [PRIO_W-1:0] prio;
        r = $urandom_range(99);
        if (r < 70) arr = TIME_W'($urandom_range(12));
        else if (r < 88) arr = TIME_W'($urandom_range(65535));
        else if (r < 94) arr = '0;
        else arr = '1;
        r = $urandom_range(99);
        if (r < 75) burst = TIME_W'($urandom_range(6, 1));
        else if (r < 85) burst = '0;
        else if (r < 95) burst = TIME_W'($urandom_range(65535));
        else burst = '1;
        if ($urandom_range(99) < 50) prio = PRIO_W'($urandom_range(3));
        else prio = PRIO_W'($urandom_range(255));
        return mk(CMD_LOAD, arr, burst, prio);
    endfunction

    // called and returns at a falling edge
    task automatic send_command(t_in c, int idle_pct);
        if ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            i_in = rand_noise();
            do @(negedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start = 1'b1;
        i_in = c;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_command(c);
        if (c.command != CMD_UNUSED) items_sent++;
        @(negedge i_clk);
    endtask

    task automatic tick(int idle_pct);
        send_command(mk(CMD_TICK, '0, '0, '0), idle_pct);
    endtask

    task automatic run_sequence(int idle_pct);
        int n;
        int cap;
        seq_no++;
        if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(4, 1)) send_command(rand_noise(), idle_pct);
        end else begin
            if ($urandom_range(99) < 85) send_command(mk(CMD_CLEAR, '0, '0, '0), idle_pct);
            n = (seq_no % 8 == 0) ? MAX_SLOTS + $urandom_range(3, 1) : $urandom_range(8, 1);
            for (int k = 0; k < n; k++) begin
                send_command(rand_load(), idle_pct);
                if ($urandom_range(99) < 25) tick(idle_pct);
            end
            cap = 30 + 10 * n;
            while (!sb.table_drained() && cap > 0) begin
                tick(idle_pct);
                cap--;
            end
            if ($urandom_range(99) < 30) tick(idle_pct);
        end
    endtask

    initial begin
        int pcts [3];
        int target;
        pcts = '{0, 66, 32};
        items_sent = 0;
        seq_no = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_in = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed
        tick(0);
        send_command(mk(CMD_UNUSED, '1, '1, '1), 0);
        send_command(mk(CMD_LOAD, 16'h1234, '0, '1), 0);
        send_command(mk(CMD_LOAD, '0, 16'd1, 8'd255), 0);
        send_command(mk(CMD_LOAD, '0, 16'd2, 8'd0), 0);
        send_command(mk(CMD_LOAD, 16'd1, 16'd1, 8'd0), 0);
        send_command(mk(CMD_LOAD, '1, '1, '0), 0);
        repeat (6) tick(0);
        send_command(mk(CMD_CLEAR, '0, '0, '0), 0);
        tick(0);

        // random sequences over idle phases
        target = items_sent;
        for (int p = 0; p < 6; p++) begin
            target += 150;
            while (items_sent < target) run_sequence(pcts[p % 3]);
        end

        start = 1'b0;
        while (sb.pending_reports.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        $display("summary: %0d loads, %0d ticks (%0d idle), %0d completions, %0d clamped waits",
                 sb.n_loads, sb.n_ticks, sb.n_idle, sb.n_finished, sb.n_clamped);
        $display("summary: %0d full-table and %0d zero-burst rejects, %0d clears, %0d unknown",
                 sb.n_full, sb.n_zero, sb.n_clears, sb.n_unknown);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/pps_pkg.sv
rtl/pps_ctrl.sv
rtl/pps_datapath.sv
rtl/preemptive_priority_scheduler.sv
test/preemptive_priority_scheduler_tb.sv
